// ===== sv/e2q_pkg.sv =====
// e2q_pkg: shared constants, types and elaboration-time functions for the
// euler_to_quaternion block (angle tables, rounding helpers, queue status).
// No dependencies.
`timescale 1ns / 1ps

package e2q_pkg;

   // default parameter values
   localparam int ANGLE_BITS_DEF      = 16;
   localparam int TRIG_ITERATIONS_DEF = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // stream word layout
   localparam int FIELD_BITS    = 16;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 64;

   // fixed-point formats
   localparam int SRC_FRAC    = 13;     // half angle read with 13 fraction bits
   localparam int Q14_FRAC    = 14;
   localparam int Q14_ONE     = 16384;
   localparam int PAIR_BITS   = 30;     // product of two Q1.14 values
   localparam int TRIPLE_BITS = 44;     // product of three Q1.14 values
   localparam int SUM_BITS    = 45;     // sum of two triple products
   localparam int TRIPLE_DROP = 28;     // Q42 down to Q14

   // cordic gain in Q32, quarter pi in Q62
   localparam logic [63:0] GAIN_Q32       = 64'h0000_0000_9B74_EDA8;
   localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243_F6A8_885A_308D;

   // queue status seen by the pipeline control
   typedef struct packed {
      logic full;
      logic empty;
   } e2q_queue_status_type;

   // series term t / (2k+1) for the arctangent expansion
   function automatic logic [63:0] odd_div(logic [63:0] t, int k);
      logic [63:0] r;
      case (k)
         0:  r = t;          1:  r = t / 64'd3;  2:  r = t / 64'd5;  3:  r = t / 64'd7;
         4:  r = t / 64'd9;  5:  r = t / 64'd11; 6:  r = t / 64'd13; 7:  r = t / 64'd15;
         8:  r = t / 64'd17; 9:  r = t / 64'd19; 10: r = t / 64'd21; 11: r = t / 64'd23;
         12: r = t / 64'd25; 13: r = t / 64'd27; 14: r = t / 64'd29; 15: r = t / 64'd31;
         16: r = t / 64'd33; 17: r = t / 64'd35; 18: r = t / 64'd37; 19: r = t / 64'd39;
         20: r = t / 64'd41; 21: r = t / 64'd43; 22: r = t / 64'd45; 23: r = t / 64'd47;
         24: r = t / 64'd49; 25: r = t / 64'd51; 26: r = t / 64'd53; 27: r = t / 64'd55;
         28: r = t / 64'd57; 29: r = t / 64'd59; 30: r = t / 64'd61; 31: r = t / 64'd63;
         default: r = '0;
      endcase
      return r;
   endfunction

   // atan(2^-i) with 62 fraction bits
   function automatic logic [63:0] atan_pow2(int i);
      logic [63:0] t;
      logic [63:0] sum;
      logic [63:0] term;
      logic        sub;
      if (i == 0) return QUARTER_PI_Q62;
      t   = 64'd1 << (62 - i);
      sum = '0;
      sub = 1'b0;
      for (int k = 0; k < 32; k++) begin
         if (t != 0) begin
            term = odd_div(t, k);
            sum  = sub ? sum - term : sum + term;
            sub  = !sub;
            t    = (2 * i < 64) ? (t >> (2 * i)) : 64'd0;
         end
      end
      return sum;
   endfunction

   // round a value with from_bits fraction bits to frac_bits, half up
   function automatic logic [63:0] round_to_f(logic [63:0] u, int from_bits, int frac_bits);
      int sh;
      sh = from_bits - frac_bits;
      if (sh <= 0) return u;
      return (u + (64'd1 << (sh - 1))) >> sh;
   endfunction

endpackage

// ===== sv/euler_to_quaternion.sv =====
// euler_to_quaternion: Euler angles (Q3.12) to a unit quaternion (Q1.14).
// Path: queue, cordic stages, Q1.14 conversion, pair, triple and output registers.
// Throughput: one word per cycle while the output is not held; lanes and products pipelined.
// A four-word queue sits between the front and the back; req_tready drops only when it fills.
// Reset clears the queue count, pointers and the stage valid bits; payload holds no reset.
`timescale 1ns / 1ps

module euler_to_quaternion #(
   parameter int ANGLE_BITS      = e2q_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [e2q_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // angle_x, angle_y, angle_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [e2q_pkg::RSP_DATA_BITS-1:0]   rsp_tdata    // quat_x, quat_y, quat_z, quat_w
);
   import e2q_pkg::*;

   localparam int ZW    = ANGLE_BITS + 4;
   localparam int LW    = ZW + 1;
   localparam int QW    = 3 * LW;
   localparam int DEPTH = TRIG_ITERATIONS + 5;

   logic [QW-1:0]        entry;
   logic [QW-1:0]        head;
   e2q_queue_status_type q_status;
   logic                 push, pop, adv;
   logic [DEPTH-1:0]     valid_ff, valid_in;

   logic signed [FIELD_BITS-1:0] cosv [3];
   logic signed [FIELD_BITS-1:0] sinv [3];

   // front: fold angles and queue them
   e2q_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .req_tdata (req_tdata),
      .entry     (entry)
   );

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   e2q_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (entry),
      .pop    (pop),
      .rdata  (head),
      .status (q_status)
   );

   // back end moves as one pipeline unless the output word is held
   assign adv = !rsp_tvalid || rsp_tready;
   assign pop = adv && !q_status.empty;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      e2q_cordic #(
         .ANGLE_BITS      (ANGLE_BITS),
         .TRIG_ITERATIONS (TRIG_ITERATIONS)
      ) u_cordic (
         .clock   (clock),
         .adv     (adv),
         .theta   (head[k*LW +: ZW]),
         .flip    (head[k*LW + ZW]),
         .cos_q14 (cosv[k]),
         .sin_q14 (sinv[k])
      );
   end

   e2q_prod u_prod (
      .clock (clock),
      .adv   (adv),
      .c1    (cosv[0]),
      .s1    (sinv[0]),
      .c2    (cosv[1]),
      .s2    (sinv[1]),
      .c3    (cosv[2]),
      .s3    (sinv[2]),
      .quat  (rsp_tdata)
   );

   // stage valid bits
   assign valid_in = {valid_ff[DEPTH-2:0], pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff[DEPTH-1];

   // a popped word always enters the first stage
   assert property (@(posedge clock) disable iff (reset) pop |=> valid_ff[0])
      else $error("popped word missing from first stage");

   // a held output word freezes every stage
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !rsp_tready) |=> $stable(valid_ff))
      else $error("pipeline moved while output held");

   // queue can only fill while the back end is not draining it
   assert property (@(posedge clock) disable iff (reset) q_status.full |-> !$past(pop))
      else $error("queue filled during a pop");

   // nothing in flight means no word appears
   assert property (@(posedge clock) disable iff (reset)
                    (valid_ff == '0 && q_status.empty) |=> !rsp_tvalid)
      else $error("result word with nothing in flight");

endmodule

// ===== sv/e2q_front.sv =====
// e2q_front: halves the three input angles and folds them into
// [-pi/2, pi/2], marking words whose sine and cosine must be negated.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_front #(
   parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
   input  logic [e2q_pkg::REQ_DATA_BITS-1:0] req_tdata,   // angle_x, angle_y, angle_z
   output logic [3*(ANGLE_BITS+5)-1:0]       entry        // lanes y, x, z: {flip, theta}
);
   import e2q_pkg::*;

   localparam int ZW  = ANGLE_BITS + 4;
   localparam int LW  = ZW + 1;
   localparam int SHL = (ANGLE_BITS >= SRC_FRAC) ? ANGLE_BITS - SRC_FRAC : 0;
   localparam int SHR = (ANGLE_BITS >= SRC_FRAC) ? 0 : SRC_FRAC - ANGLE_BITS;

   localparam logic signed [ZW-1:0] PI_F = ZW'(round_to_f(QUARTER_PI_Q62, 60, ANGLE_BITS));
   localparam logic signed [ZW-1:0] HP_F = ZW'(round_to_f(QUARTER_PI_Q62, 61, ANGLE_BITS));

   logic signed [FIELD_BITS-1:0] ang   [3];
   logic signed [ZW-1:0]         theta [3];
   logic signed [ZW-1:0]         fold  [3];
   logic                         flip  [3];

   // lane order follows the product terms: y first, then x, then z
   assign ang[0] = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign ang[1] = req_tdata[FIELD_BITS-1:0];
   assign ang[2] = req_tdata[3*FIELD_BITS-1:2*FIELD_BITS];

   // scale the half angle and fold it into range
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         theta[k] = (ZW'(ang[k]) <<< SHL) >>> SHR;
         if (theta[k] > HP_F) begin
            fold[k] = theta[k] - PI_F;
            flip[k] = 1'b1;
         end else if (theta[k] < -HP_F) begin
            fold[k] = theta[k] + PI_F;
            flip[k] = 1'b1;
         end else begin
            fold[k] = theta[k];
            flip[k] = 1'b0;
         end
         entry[k*LW +: LW] = {flip[k], fold[k]};
      end
   end

endmodule

// ===== sv/e2q_queue.sv =====
// e2q_queue: short first-in first-out queue of folded angle words
// between the front and the cordic back end.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = e2q_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              wdata,
   input  logic                          pop,
   output logic [WIDTH-1:0]              rdata,
   output e2q_pkg::e2q_queue_status_type status
);
   import e2q_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign rdata        = mem_ff[rd_ptr_ff];

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wdata;
   end

endmodule

// ===== sv/e2q_cordic.sv =====
// e2q_cordic: one pipelined rotation-mode cordic lane, one stage per
// iteration, then sign fix-up and conversion of sine and cosine to Q1.14.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_cordic #(
   parameter int ANGLE_BITS      = e2q_pkg::ANGLE_BITS_DEF,
   parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [ANGLE_BITS+3:0]         theta,
   input  logic                                 flip,
   output logic signed [e2q_pkg::FIELD_BITS-1:0] cos_q14,
   output logic signed [e2q_pkg::FIELD_BITS-1:0] sin_q14
);
   import e2q_pkg::*;

   localparam int ZW  = ANGLE_BITS + 4;
   localparam int XW  = ANGLE_BITS + 3;
   localparam int CW  = XW + 2;
   localparam int N   = TRIG_ITERATIONS;
   localparam int SR  = (ANGLE_BITS > Q14_FRAC) ? ANGLE_BITS - Q14_FRAC : 0;
   localparam int SL  = (ANGLE_BITS < Q14_FRAC) ? Q14_FRAC - ANGLE_BITS : 0;

   localparam logic signed [XW-1:0] K_INIT = XW'(round_to_f(GAIN_Q32, 32, ANGLE_BITS));
   localparam logic signed [CW-1:0] RND    = (SR > 0) ? CW'(64'd1 << (SR - 1)) : '0;
   localparam logic signed [CW-1:0] SAT_HI = CW'(Q14_ONE);

   logic signed [ZW-1:0] z_ff    [0:N-1];
   logic                 flip_ff [0:N];
   logic signed [XW-1:0] x_ff    [1:N];
   logic signed [XW-1:0] y_ff    [1:N];

   logic signed [FIELD_BITS-1:0] cos_ff, cos_in;
   logic signed [FIELD_BITS-1:0] sin_ff, sin_in;

   // entry stage holds the folded angle
   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff[0]    <= theta;
         flip_ff[0] <= flip;
      end
   end

   // one iteration per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic signed [ZW-1:0] AT = ZW'(round_to_f(atan_pow2(i), 62, ANGLE_BITS));
      logic signed [XW-1:0] xi, yi, x_in, y_in;
      logic                 up;

      if (i == 0) begin : g_first
         assign xi = K_INIT;
         assign yi = '0;
      end else begin : g_next
         assign xi = x_ff[i];
         assign yi = y_ff[i];
      end

      assign up   = !z_ff[i][ZW-1];
      assign x_in = up ? xi - (yi >>> i) : xi + (yi >>> i);
      assign y_in = up ? yi + (xi >>> i) : yi - (xi >>> i);

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            flip_ff[i+1] <= flip_ff[i];
         end
      end

      if (i < N - 1) begin : g_angle
         logic signed [ZW-1:0] z_in;
         assign z_in = up ? z_ff[i] - AT : z_ff[i] + AT;
         always_ff @(posedge clock) begin
            if (adv) z_ff[i+1] <= z_in;
         end
      end
   end

   // undo the fold, round to Q1.14 and saturate
   function automatic logic signed [FIELD_BITS-1:0] to_q14(logic signed [XW-1:0] v,
                                                          logic neg);
      logic signed [CW-1:0] e;
      logic signed [CW-1:0] r;
      e = CW'(v);
      if (neg) e = -e;
      r = ((e + RND) <<< SL) >>> SR;
      if (r > SAT_HI)       r = SAT_HI;
      else if (r < -SAT_HI) r = -SAT_HI;
      return FIELD_BITS'(r);
   endfunction

   assign cos_in = to_q14(x_ff[N], flip_ff[N]);
   assign sin_in = to_q14(y_ff[N], flip_ff[N]);

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q14 = cos_ff;
   assign sin_q14 = sin_ff;

endmodule

// ===== sv/e2q_prod.sv =====
// e2q_prod: pair products, triple products, then sum, round and saturate
// into the four quaternion components; the last stage is the output register.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_prod (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] c1,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] s1,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] c2,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] s2,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] c3,
   input  logic signed [e2q_pkg::FIELD_BITS-1:0] s3,
   output logic [e2q_pkg::RSP_DATA_BITS-1:0]     quat      // quat_x, quat_y, quat_z, quat_w
);
   import e2q_pkg::*;

   localparam logic signed [SUM_BITS-1:0] ROUND  = SUM_BITS'(64'd1 << (TRIPLE_DROP - 1));
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(Q14_ONE);

   logic signed [PAIR_BITS-1:0]   cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [FIELD_BITS-1:0]  c3_ff, s3_ff;
   logic signed [TRIPLE_BITS-1:0] tri_ff [8];
   logic signed [TRIPLE_BITS-1:0] tri_in [8];
   logic [RSP_DATA_BITS-1:0]      quat_ff, quat_in;

   // sum or difference of two Q42 terms rounded half up to Q1.14, saturated to one
   function automatic logic [FIELD_BITS-1:0] round_sat(logic signed [TRIPLE_BITS-1:0] p,
                                                       logic signed [TRIPLE_BITS-1:0] q,
                                                       logic sub);
      logic signed [SUM_BITS-1:0] v;
      logic signed [SUM_BITS-1:0] r;
      v = sub ? SUM_BITS'(p) - SUM_BITS'(q) : SUM_BITS'(p) + SUM_BITS'(q);
      r = (v + ROUND) >>> TRIPLE_DROP;
      if (r > SAT_HI)       r = SAT_HI;
      else if (r < -SAT_HI) r = -SAT_HI;
      return FIELD_BITS'(r);
   endfunction

   // pair products of the y and x lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff <= PAIR_BITS'(c1) * PAIR_BITS'(c2);
         ss_ff <= PAIR_BITS'(s1) * PAIR_BITS'(s2);
         sc_ff <= PAIR_BITS'(s1) * PAIR_BITS'(c2);
         cs_ff <= PAIR_BITS'(c1) * PAIR_BITS'(s2);
         c3_ff <= c3;
         s3_ff <= s3;
      end
   end

   // triple products, in pairs per component x, y, z, w
   assign tri_in[0] = TRIPLE_BITS'(ss_ff) * TRIPLE_BITS'(c3_ff);
   assign tri_in[1] = TRIPLE_BITS'(cc_ff) * TRIPLE_BITS'(s3_ff);
   assign tri_in[2] = TRIPLE_BITS'(sc_ff) * TRIPLE_BITS'(c3_ff);
   assign tri_in[3] = TRIPLE_BITS'(cs_ff) * TRIPLE_BITS'(s3_ff);
   assign tri_in[4] = TRIPLE_BITS'(cs_ff) * TRIPLE_BITS'(c3_ff);
   assign tri_in[5] = TRIPLE_BITS'(sc_ff) * TRIPLE_BITS'(s3_ff);
   assign tri_in[6] = TRIPLE_BITS'(cc_ff) * TRIPLE_BITS'(c3_ff);
   assign tri_in[7] = TRIPLE_BITS'(ss_ff) * TRIPLE_BITS'(s3_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++) tri_ff[k] <= tri_in[k];
      end
   end

   // combine into the output word
   assign quat_in = {round_sat(tri_ff[6], tri_ff[7], 1'b1),
                     round_sat(tri_ff[4], tri_ff[5], 1'b1),
                     round_sat(tri_ff[2], tri_ff[3], 1'b0),
                     round_sat(tri_ff[0], tri_ff[1], 1'b0)};

   always_ff @(posedge clock) begin
      if (adv) quat_ff <= quat_in;
   end

   assign quat = quat_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for euler_to_quaternion; streams angle words in and
// checks each quaternion word against a fixed-point cordic predictor kept in the bench
// depends on e2q_pkg and euler_to_quaternion

module tb_top;
   import e2q_pkg::*;

   localparam int PIPE_LATENCY   = TRIG_ITERATIONS_DEF + 5;
   localparam int CORDIC_STEPS   = TRIG_ITERATIONS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int IDLE_PERCENT   = 31;
   localparam longint UNIT_Q14   = 16384;

   // angle word: angle_x lowest, quaternion word: quat_x lowest
   typedef struct packed {
      logic signed [15:0] angle_z;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_x;
   } angles_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
   } quat_type;

   typedef struct packed {
      angles_type angles;
      quat_type   quat;
   } pending_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // angle_x, angle_y, angle_z
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // quat_x, quat_y, quat_z, quat_w

   pending_type expected_quats[$];
   bit       idling_on = 1'b1;
   int       error_count = 0;
   int       items_sent = 0;
   int       directed_count = 0;
   int       quats_checked = 0;
   int       clamp_hits = 0;
   int       quiet_cycles = 0;
   string    quat_names [4] = '{"quat_x", "quat_y", "quat_z", "quat_w"};

   // trig constants at 16 fraction bits
   longint gain_f, pi_f, half_pi_f;
   longint atan_f [CORDIC_STEPS];

   euler_to_quaternion u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // alternating arctan series, t divided by ratio each term
   function automatic longint unsigned arctan_series(longint unsigned t,
                                                     longint unsigned ratio);
      longint unsigned sum;
      longint unsigned k;
      bit              negate;
      sum    = 0;
      k      = 0;
      negate = 1'b0;
      while (t != 0) begin
         sum    = negate ? sum - t / (2 * k + 1) : sum + t / (2 * k + 1);
         negate = !negate;
         t      = t / ratio;
         k++;
      end
      return sum;
   endfunction

   function automatic longint round_to_q16(longint unsigned u, int from_bits);
      int sh;
      sh = from_bits - 16;
      return longint'((u + (64'd1 << (sh - 1))) >> sh);
   endfunction

   initial begin
      longint unsigned quarter_pi;
      quarter_pi = 4 * arctan_series((64'd1 << 62) / 5, 25)
                   - arctan_series((64'd1 << 62) / 239, 239 * 239);
      pi_f      = round_to_q16(quarter_pi, 60);
      half_pi_f = round_to_q16(quarter_pi, 61);
      gain_f    = round_to_q16(64'h9B74_EDA8, 32);
      atan_f[0] = round_to_q16(quarter_pi, 62);
      for (int i = 1; i < CORDIC_STEPS; i++)
         atan_f[i] = round_to_q16(arctan_series(64'd1 << (62 - i), 64'd1 << (2 * i)), 62);
   end

   function automatic longint clamp_unit(longint v);
      if (v > UNIT_Q14) return UNIT_Q14;
      if (v < -UNIT_Q14) return -UNIT_Q14;
      return v;
   endfunction

   // cosine and sine of half the angle, q1.14
   function automatic void half_angle_trig(input logic signed [15:0] angle,
                                           output longint cos_q14, output longint sin_q14);
      longint th, cx, cy, dx, dy;
      bit     fold;
      th   = angle;
      th   = th * 8;
      fold = 1'b0;
      // fold the half angle into [-pi/2, pi/2]
      if (th > half_pi_f) begin
         th   = th - pi_f;
         fold = 1'b1;
      end else if (th < -half_pi_f) begin
         th   = th + pi_f;
         fold = 1'b1;
      end
      cx = gain_f;
      cy = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (th >= 0) begin
            cx = cx - dx;
            cy = cy + dy;
            th = th - atan_f[i];
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            th = th + atan_f[i];
         end
      end
      if (fold) begin
         cx = -cx;
         cy = -cy;
      end
      cos_q14 = clamp_unit((cx + 2) >>> 2);
      sin_q14 = clamp_unit((cy + 2) >>> 2);
   endfunction

   // two q42 triple products to a rounded, clamped q1.14 component
   function automatic logic [15:0] round_sum(longint p, longint q, bit subtract);
      longint v;
      v = subtract ? p - q : p + q;
      v = clamp_unit((v + (longint'(1) <<< 27)) >>> 28);
      return v[15:0];
   endfunction

   function automatic quat_type predict_quat(angles_type a);
      longint c1, s1, c2, s2, c3, s3;
      quat_type q;
      half_angle_trig(a.angle_y, c1, s1);
      half_angle_trig(a.angle_x, c2, s2);
      half_angle_trig(a.angle_z, c3, s3);
      q.quat_x = round_sum(s1 * s2 * c3, c1 * c2 * s3, 1'b0);
      q.quat_y = round_sum(s1 * c2 * c3, c1 * s2 * s3, 1'b0);
      q.quat_z = round_sum(c1 * s2 * c3, s1 * c2 * s3, 1'b1);
      q.quat_w = round_sum(c1 * c2 * c3, s1 * s2 * s3, 1'b1);
      return q;
   endfunction

   function automatic void report_mismatch(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // send one angle word, record its prediction once accepted
   task automatic push_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      angles_type  a;
      pending_type p;
      a.angle_x = ax;
      a.angle_y = ay;
      a.angle_z = az;
      // idle cycle by cycle so about a third of the cycles carry no word
      while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = a;
      do @(posedge clock); while (!req_tready);
      p.angles = a;
      p.quat   = predict_quat(a);
      expected_quats.push_back(p);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (expected_quats.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // random angle, weighted toward the fold boundary and the extremes
   function automatic logic signed [15:0] pick_angle();
      int v;
      case ($urandom_range(0, 7))
         0, 1, 2: v = $urandom;
         3:       v = ($urandom_range(0, 1) ? 12868 : -12868) + $urandom_range(0, 16) - 8;
         4:       v = $urandom_range(0, 600) - 300;
         5: begin
            case ($urandom_range(0, 4))
               0:       v = 32767;
               1:       v = -32768;
               2:       v = 0;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         6:       v = ($urandom_range(0, 1) ? 25736 : -25736) + $urandom_range(0, 16) - 8;
         default: v = $urandom_range(0, 16384) - 8192;
      endcase
      return v[15:0];
   endfunction

   // extremes, axis-only rotations, and half angles on both sides of the fold
   task automatic run_directed_angles();
      push_angles(0, 0, 0);
      push_angles(32767, 0, 0);
      push_angles(-32768, 0, 0);
      push_angles(0, 32767, 0);
      push_angles(0, -32768, 0);
      push_angles(0, 0, 32767);
      push_angles(0, 0, -32768);
      push_angles(32767, 32767, 32767);
      push_angles(-32768, -32768, -32768);
      push_angles(32767, -32768, 32767);
      push_angles(12868, 12868, 12868);
      push_angles(12869, 12869, 12869);
      push_angles(-12868, -12868, -12868);
      push_angles(-12869, -12869, -12869);
      push_angles(12868, -12869, 12869);
      push_angles(6434, 6434, 6434);
      push_angles(25736, -25736, 12868);
      push_angles(-1, 1, -1);
      push_angles(1, 1, 1);
      push_angles(4096, -4096, 8192);
      directed_count = items_sent;
   endtask

   task automatic run_random_angles(int count, bit with_idling);
      idling_on = with_idling;
      repeat (count) push_angles(pick_angle(), pick_angle(), pick_angle());
      idling_on = 1'b1;
   endtask

   // sender holds off until the pipeline is empty, then resumes
   task automatic run_drain_pause();
      req_tvalid = 1'b0;
      wait_for_drain();
      repeat (30) push_angles(pick_angle(), pick_angle(), pick_angle());
   endtask

   // receiver stalls at random while idling is on
   always @(negedge clock) begin
      rsp_tready = idling_on ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
   end

   // compare each accepted quaternion with the oldest prediction
   always @(posedge clock) begin
      pending_type head;
      logic [63:0] got;
      logic [63:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_quats.size() == 0) begin
            report_mismatch($sformatf("quaternion word %h with no pending angles", got));
         end else begin
            head = expected_quats.pop_front();
            want = head.quat;
            quats_checked++;
            for (int f = 0; f < 4; f++) begin
               if (want[16 * f +: 16] == 16'sd16384 || want[16 * f +: 16] == -16'sd16384)
                  clamp_hits++;
               if (got[16 * f +: 16] !== want[16 * f +: 16])
                  report_mismatch($sformatf("%s for angles x=%0d y=%0d z=%0d: exp %0d got %0d",
                     quat_names[f], head.angles.angle_x, head.angles.angle_y,
                     head.angles.angle_z, $signed(want[16 * f +: 16]),
                     $signed(got[16 * f +: 16])));
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d quaternions outstanding",
                  quiet_cycles, expected_quats.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed_angles();
      run_random_angles(300, 1'b1);
      run_random_angles(200, 1'b0);
      run_drain_pause();
      run_random_angles(420, 1'b1);

      req_tvalid = 1'b0;
      wait_for_drain();
      repeat (PIPE_LATENCY + 16) @(posedge clock);

      $display("covered %0d angle triples (%0d directed), %0d quaternions checked",
               items_sent, directed_count, quats_checked);
      $display("%0d components at the unit clamp, %0d mismatches", clamp_hits, error_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
